/* hw/rtl/hawt_pkg.sv */
package hawt_pkg;

  localparam int unsigned CmdWidth = 2;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 8;
  localparam int unsigned MinuteWidth = 8;
  localparam int unsigned SecondWidth = 6;
  localparam int unsigned TempWidth = 9;
  localparam int unsigned SetWidth = 7;
  localparam int unsigned BoostWidth = 4;

  localparam logic [CmdWidth-1:0] CMD_STEP  = 2'd0;
  localparam logic [CmdWidth-1:0] CMD_START = 2'd1;
  localparam logic [CmdWidth-1:0] CMD_RESET = 2'd2;

  localparam logic [CfgIndexWidth-1:0] REG_MAX_WAIT   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_BASE_WAIT  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_BURST      = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_START_WAIT = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_HOLD_WAIT  = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_SP_CAP     = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_LOW_LIMIT  = 3'd6;
  localparam logic [CfgIndexWidth-1:0] REG_LOW_BOOST  = 3'd7;

  localparam logic [MinuteWidth-1:0] RST_MAX_WAIT   = 8'd103;
  localparam logic [MinuteWidth-1:0] RST_BASE_WAIT  = 8'd6;
  localparam logic [MinuteWidth-1:0] RST_BURST      = 8'd3;
  localparam logic [MinuteWidth-1:0] RST_START_WAIT = 8'd3;
  localparam logic [MinuteWidth-1:0] RST_HOLD_WAIT  = 8'd12;
  localparam logic [SetWidth-1:0]    RST_SP_CAP     = 7'd60;
  localparam logic [SetWidth-1:0]    RST_LOW_LIMIT  = 7'd20;
  localparam logic [BoostWidth-1:0]  RST_LOW_BOOST  = 4'd3;

  localparam logic [SecondWidth-1:0] LAST_SECOND = 6'd59;
  localparam logic [MinuteWidth-1:0] MINUTE_SAT  = 8'd255;

  typedef struct packed {
    logic                   heater_drive;
    logic                   fan_drive;
    logic                   heating_request;
    logic [MinuteWidth-1:0] wait_minutes;
  } result_t;

endpackage

/* hw/rtl/heater_adaptive_wait_thermostat_unit.sv */
// Channel  Direction  Handshake           Beat
// in       to block   in_valid/in_stall   cmd, flags, set_temp, measured_temp, strobes
// out      from block out_valid/out_stall heater_drive, fan_drive, heating_request,
//                                          wait_minutes
// cfg      to block   cfg_write           cfg_index, cfg_data
//
// One beat per cycle while in_stall is low; a beat's result is registered.
// Control state is updated in the accept cycle, so back-to-back beats chain.
// A two-entry result stage (output register plus skid) absorbs one out stall;
// in_stall rises only when both entries are full.
// rst is synchronous: state, configuration and result valids return to defaults.
module heater_adaptive_wait_thermostat_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [hawt_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  logic [hawt_pkg::CfgDataWidth-1:0]      cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [hawt_pkg::CmdWidth-1:0]          cmd,
  input  logic                                   unit_running,
  input  logic                                   heater_enable,
  input  logic                                   error_active,
  input  logic                                   error_stop,
  input  logic [hawt_pkg::SetWidth-1:0]          set_temp,
  input  logic signed [hawt_pkg::TempWidth-1:0]  measured_temp,
  input  logic                                   tick_second,
  input  logic                                   hot_delay_done,
  input  logic                                   fan_delay_done,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   heater_drive,
  output logic                                   fan_drive,
  output logic                                   heating_request,
  output logic [hawt_pkg::MinuteWidth-1:0]       wait_minutes
);

  logic [7:0] max_wait, base_wait, burst, start_wait, hold_wait;
  logic [6:0] sp_cap, low_limit;
  logic [3:0] low_boost;

  logic       heat_request, fall_wait_flag, hot_delay_flag, fan_delay_flag;
  logic [5:0] second_count;
  logic [7:0] off_minutes, adaptive_wait;
  logic       heater_reg, fan_reg;

  logic       heat_request_next, fall_wait_flag_next, hot_delay_flag_next;
  logic       fan_delay_flag_next, heater_reg_next, fan_reg_next;
  logic [5:0] second_count_next;
  logic [7:0] off_minutes_next, adaptive_wait_next;

  logic              accept;
  logic [9:0]        sp;
  logic signed [10:0] sp_s, meas_s;
  logic              heat_on, heat_off;
  logic [8:0]        sum_off, grown;
  logic [7:0]        shrunk;
  logic              hold_path;

  hawt_pkg::result_t result_new, out_data, skid_data;
  logic              skid_valid;

  assign accept = in_valid && !in_stall;
  assign in_stall = skid_valid;

  always_comb begin
    if (set_temp >= sp_cap) begin
      sp = {2'b00, sp_cap, 1'b0};
    end else if (set_temp <= low_limit) begin
      sp = {2'b00, set_temp, 1'b0} + {6'b000000, low_boost};
    end else begin
      sp = {2'b00, set_temp, 1'b0};
    end
  end

  assign sp_s     = $signed({1'b0, sp});
  assign meas_s   = $signed({{2{measured_temp[8]}}, measured_temp});
  assign heat_on  = sp_s >= meas_s + 11'sd2;
  assign heat_off = sp_s <= meas_s - 11'sd2;

  always_comb begin
    heat_request_next   = heat_request;
    fall_wait_flag_next = fall_wait_flag;
    hot_delay_flag_next = hot_delay_flag;
    fan_delay_flag_next = fan_delay_flag;
    second_count_next   = second_count;
    off_minutes_next    = off_minutes;
    adaptive_wait_next  = adaptive_wait;
    heater_reg_next     = heater_reg;
    fan_reg_next        = fan_reg;
    sum_off             = '0;
    grown               = '0;
    shrunk              = '0;
    hold_path           = 1'b0;

    if (hot_delay_done) begin
      hot_delay_flag_next = 1'b0;
    end
    if (fan_delay_done) begin
      fan_delay_flag_next = 1'b0;
    end

    case (cmd)
      hawt_pkg::CMD_STEP: begin
        if (error_stop && unit_running) begin
          fan_reg_next        = 1'b0;
          fan_delay_flag_next = 1'b0;
          hot_delay_flag_next = 1'b0;
        end else if (!unit_running || !heater_enable || error_active) begin
          heater_reg_next     = 1'b0;
          heat_request_next   = 1'b0;
          hot_delay_flag_next = 1'b0;
          if (!fan_delay_flag_next) begin
            fan_reg_next = 1'b0;
          end
        end else begin
          if (heat_on) begin
            if (!heat_request_next) begin
              hot_delay_flag_next = 1'b1;
              heat_request_next   = 1'b1;
              adaptive_wait_next  = base_wait;
            end
            if (fall_wait_flag_next) begin
              fall_wait_flag_next = 1'b0;
              sum_off = {1'b0, off_minutes_next} + {1'b0, burst};
              if (sum_off > {1'b0, adaptive_wait_next}) begin
                shrunk = (adaptive_wait_next > burst) ? adaptive_wait_next - burst : 8'd0;
                if (shrunk <= base_wait) begin
                  shrunk = base_wait;
                end
                adaptive_wait_next = shrunk;
              end
            end
            off_minutes_next  = '0;
            second_count_next = '0;
          end else begin
            if (heat_off) begin
              if (heat_request_next && !fall_wait_flag_next) begin
                heat_request_next = 1'b0;
                if (adaptive_wait_next <= start_wait) begin
                  adaptive_wait_next = base_wait;
                end
              end
            end else if (heat_request_next) begin
              hold_path = !fall_wait_flag_next;
            end else begin
              adaptive_wait_next = hold_wait;
            end
            if (tick_second && !hold_path) begin
              second_count_next = second_count_next + 6'd1;
              if (second_count_next > hawt_pkg::LAST_SECOND) begin
                second_count_next = '0;
                if (off_minutes_next < hawt_pkg::MINUTE_SAT) begin
                  off_minutes_next = off_minutes_next + 8'd1;
                end
                sum_off = {1'b0, off_minutes_next} + {1'b0, burst};
                if (sum_off >= {1'b0, adaptive_wait_next}) begin
                  fall_wait_flag_next = 1'b1;
                  hot_delay_flag_next = 1'b1;
                  heat_request_next   = 1'b1;
                  if (off_minutes_next >= adaptive_wait_next) begin
                    grown = {1'b0, adaptive_wait_next} + {1'b0, burst};
                    if (grown >= {1'b0, max_wait}) begin
                      adaptive_wait_next = max_wait;
                    end else begin
                      adaptive_wait_next = grown[7:0];
                    end
                    heat_request_next   = 1'b0;
                    fall_wait_flag_next = 1'b0;
                    off_minutes_next    = '0;
                    second_count_next   = '0;
                  end
                end
              end
            end
          end
          if (heat_request_next) begin
            if (!hot_delay_flag_next) begin
              heater_reg_next = 1'b1;
            end
            fan_reg_next        = 1'b1;
            fan_delay_flag_next = 1'b1;
          end else begin
            heater_reg_next = 1'b0;
            if (!fan_delay_flag_next) begin
              fan_reg_next = 1'b0;
            end
            hot_delay_flag_next = 1'b0;
          end
        end
      end
      hawt_pkg::CMD_START: begin
        hot_delay_flag_next = 1'b1;
        heat_request_next   = 1'b1;
        fall_wait_flag_next = 1'b1;
        adaptive_wait_next  = start_wait;
        off_minutes_next    = '0;
        second_count_next   = '0;
      end
      hawt_pkg::CMD_RESET: begin
        heat_request_next   = 1'b0;
        fall_wait_flag_next = 1'b0;
        off_minutes_next    = '0;
        second_count_next   = '0;
        adaptive_wait_next  = base_wait;
      end
      default: begin
      end
    endcase
  end

  assign result_new.heater_drive    = heater_reg_next;
  assign result_new.fan_drive       = fan_reg_next;
  assign result_new.heating_request = heat_request_next;
  assign result_new.wait_minutes    = adaptive_wait_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_wait   <= hawt_pkg::RST_MAX_WAIT;
      base_wait  <= hawt_pkg::RST_BASE_WAIT;
      burst      <= hawt_pkg::RST_BURST;
      start_wait <= hawt_pkg::RST_START_WAIT;
      hold_wait  <= hawt_pkg::RST_HOLD_WAIT;
      sp_cap     <= hawt_pkg::RST_SP_CAP;
      low_limit  <= hawt_pkg::RST_LOW_LIMIT;
      low_boost  <= hawt_pkg::RST_LOW_BOOST;
    end else if (cfg_write) begin
      case (cfg_index)
        hawt_pkg::REG_MAX_WAIT:   max_wait   <= cfg_data;
        hawt_pkg::REG_BASE_WAIT:  base_wait  <= cfg_data;
        hawt_pkg::REG_BURST:      burst      <= cfg_data;
        hawt_pkg::REG_START_WAIT: start_wait <= cfg_data;
        hawt_pkg::REG_HOLD_WAIT:  hold_wait  <= cfg_data;
        hawt_pkg::REG_SP_CAP:     sp_cap     <= cfg_data[6:0];
        hawt_pkg::REG_LOW_LIMIT:  low_limit  <= cfg_data[6:0];
        hawt_pkg::REG_LOW_BOOST:  low_boost  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_request   <= 1'b0;
      fall_wait_flag <= 1'b0;
      hot_delay_flag <= 1'b0;
      fan_delay_flag <= 1'b0;
      second_count   <= '0;
      off_minutes    <= '0;
      adaptive_wait  <= hawt_pkg::RST_BASE_WAIT;
      heater_reg     <= 1'b0;
      fan_reg        <= 1'b0;
    end else if (accept) begin
      heat_request   <= heat_request_next;
      fall_wait_flag <= fall_wait_flag_next;
      hot_delay_flag <= hot_delay_flag_next;
      fan_delay_flag <= fan_delay_flag_next;
      second_count   <= second_count_next;
      off_minutes    <= off_minutes_next;
      adaptive_wait  <= adaptive_wait_next;
      heater_reg     <= heater_reg_next;
      fan_reg        <= fan_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : result_new;
    end else if (accept) begin
      skid_data <= result_new;
    end
  end

  assign heater_drive    = out_data.heater_drive;
  assign fan_drive       = out_data.fan_drive;
  assign heating_request = out_data.heating_request;
  assign wait_minutes    = out_data.wait_minutes;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a pending result");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled while output was free");

  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    second_count <= hawt_pkg::LAST_SECOND)
    else $error("second counter out of range");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

/* verif/tb_heater_adaptive_wait_thermostat_unit.sv */
module tb_heater_adaptive_wait_thermostat_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hawt_pkg::*;

  localparam logic [CmdWidth-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int TEMP_LO = -80;
  localparam int TEMP_HI = 250;

  typedef struct {
    logic [CmdWidth-1:0]          cmd;
    logic                         unit_running;
    logic                         heater_enable;
    logic                         error_active;
    logic                         error_stop;
    logic [SetWidth-1:0]          set_temp;
    logic signed [TempWidth-1:0]  measured_temp;
    logic                         tick_second;
    logic                         hot_delay_done;
    logic                         fan_delay_done;
  } climate_beat_t;

  class thermo_scoreboard;
    bit [MinuteWidth-1:0] max_wait, base_wait, burst, start_wait, hold_wait;
    bit [SetWidth-1:0]    sp_cap, low_limit;
    bit [BoostWidth-1:0]  low_boost;
    bit                   heat_req, fall_wait, hot_dly, fan_dly, heater, fan;
    int unsigned          sec_cnt, off_min, wait_min;
    result_t              expected_q[$];
    int unsigned          errors;

    function new();
      max_wait = RST_MAX_WAIT;
      base_wait = RST_BASE_WAIT;
      burst = RST_BURST;
      start_wait = RST_START_WAIT;
      hold_wait = RST_HOLD_WAIT;
      sp_cap = RST_SP_CAP;
      low_limit = RST_LOW_LIMIT;
      low_boost = RST_LOW_BOOST;
      heat_req = 1'b0;
      fall_wait = 1'b0;
      hot_dly = 1'b0;
      fan_dly = 1'b0;
      heater = 1'b0;
      fan = 1'b0;
      sec_cnt = 0;
      off_min = 0;
      wait_min = RST_BASE_WAIT;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        REG_MAX_WAIT:   max_wait = data;
        REG_BASE_WAIT:  base_wait = data;
        REG_BURST:      burst = data;
        REG_START_WAIT: start_wait = data;
        REG_HOLD_WAIT:  hold_wait = data;
        REG_SP_CAP:     sp_cap = data[SetWidth-1:0];
        REG_LOW_LIMIT:  low_limit = data[SetWidth-1:0];
        REG_LOW_BOOST:  low_boost = data[BoostWidth-1:0];
        default: ;
      endcase
    endfunction

    function int target_half_deg(logic [SetWidth-1:0] set_temp);
      if (set_temp >= sp_cap) begin
        return int'(sp_cap) * 2;
      end else if (set_temp <= low_limit) begin
        return int'(set_temp) * 2 + int'(low_boost);
      end
      return int'(set_temp) * 2;
    endfunction

    function void drive_loads();
      if (heat_req) begin
        if (!hot_dly) heater = 1'b1;
        fan = 1'b1;
        fan_dly = 1'b1;
      end else begin
        heater = 1'b0;
        if (!fan_dly) fan = 1'b0;
        hot_dly = 1'b0;
      end
    endfunction

    function void count_second();
      int unsigned grown;
      sec_cnt++;
      if (sec_cnt <= int'(LAST_SECOND)) return;
      sec_cnt = 0;
      if (off_min < MINUTE_SAT) off_min++;
      if (off_min + burst >= wait_min) begin
        fall_wait = 1'b1;
        hot_dly = 1'b1;
        heat_req = 1'b1;
        if (off_min >= wait_min) begin
          grown = wait_min + burst;
          if (grown >= max_wait) grown = max_wait;
          wait_min = grown;
          heat_req = 1'b0;
          fall_wait = 1'b0;
          off_min = 0;
          sec_cnt = 0;
        end
      end
    endfunction

    function void control(climate_beat_t b);
      int sp;
      int meas;
      int unsigned shrunk;
      if (b.error_stop && b.unit_running) begin
        fan = 1'b0;
        fan_dly = 1'b0;
        hot_dly = 1'b0;
        return;
      end
      if (!b.unit_running || !b.heater_enable || b.error_active) begin
        heater = 1'b0;
        heat_req = 1'b0;
        hot_dly = 1'b0;
        if (!fan_dly) fan = 1'b0;
        return;
      end
      sp = target_half_deg(b.set_temp);
      meas = int'(b.measured_temp);
      if (sp >= meas + 2) begin
        if (!heat_req) begin
          hot_dly = 1'b1;
          heat_req = 1'b1;
          wait_min = base_wait;
        end
        if (fall_wait) begin
          fall_wait = 1'b0;
          if (off_min + burst > wait_min) begin
            shrunk = (wait_min > burst) ? wait_min - burst : 0;
            if (shrunk <= base_wait) shrunk = base_wait;
            wait_min = shrunk;
          end
        end
        off_min = 0;
        sec_cnt = 0;
      end else begin
        if (sp <= meas - 2) begin
          if (heat_req && !fall_wait) begin
            heat_req = 1'b0;
            if (wait_min <= start_wait) wait_min = base_wait;
          end
        end else if (heat_req) begin
          if (!fall_wait) begin
            drive_loads();
            return;
          end
        end else begin
          wait_min = hold_wait;
        end
        if (b.tick_second) count_second();
      end
      drive_loads();
    endfunction

    function void note_beat(climate_beat_t b);
      if (b.hot_delay_done) hot_dly = 1'b0;
      if (b.fan_delay_done) fan_dly = 1'b0;
      case (b.cmd)
        CMD_STEP: control(b);
        CMD_START: begin
          hot_dly = 1'b1;
          heat_req = 1'b1;
          fall_wait = 1'b1;
          wait_min = start_wait;
          off_min = 0;
          sec_cnt = 0;
        end
        CMD_RESET: begin
          heat_req = 1'b0;
          fall_wait = 1'b0;
          off_min = 0;
          sec_cnt = 0;
          wait_min = base_wait;
        end
        default: ;
      endcase
      expected_q.push_back(result_t'{heater, fan, heat_req, wait_min[MinuteWidth-1:0]});
    endfunction

    function void compare_field(string what, int unsigned want, int unsigned got);
      if (want == got) return;
      errors++;
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t result beat with nothing pending: %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("heater_drive", want.heater_drive, got.heater_drive);
      compare_field("fan_drive", want.fan_drive, got.fan_drive);
      compare_field("heating_request", want.heating_request, got.heating_request);
      compare_field("wait_minutes", want.wait_minutes, got.wait_minutes);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0]    cfg_index = REG_MAX_WAIT;
  logic [CfgDataWidth-1:0]     cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CmdWidth-1:0]         cmd = CMD_STEP;
  logic                        unit_running = 1'b0;
  logic                        heater_enable = 1'b0;
  logic                        error_active = 1'b0;
  logic                        error_stop = 1'b0;
  logic [SetWidth-1:0]         set_temp = '0;
  logic signed [TempWidth-1:0] measured_temp = '0;
  logic                        tick_second = 1'b0;
  logic                        hot_delay_done = 1'b0;
  logic                        fan_delay_done = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        heater_drive;
  logic                        fan_drive;
  logic                        heating_request;
  logic [MinuteWidth-1:0]      wait_minutes;

  thermo_scoreboard sb;
  int unsigned      beats_left = 0;
  int unsigned      cycle_count = 0;
  int unsigned      stall_phase = 0;
  int unsigned      stall_mode = 0;

  heater_adaptive_wait_thermostat_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .unit_running    (unit_running),
    .heater_enable   (heater_enable),
    .error_active    (error_active),
    .error_stop      (error_stop),
    .set_temp        (set_temp),
    .measured_temp   (measured_temp),
    .tick_second     (tick_second),
    .hot_delay_done  (hot_delay_done),
    .fan_delay_done  (fan_delay_done),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .heater_drive    (heater_drive),
    .fan_drive       (fan_drive),
    .heating_request (heating_request),
    .wait_minutes    (wait_minutes)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    stall_phase++;
    if (stall_phase % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_phase[2];
    endcase
  end

  always @(posedge clk) begin
    climate_beat_t seen;
    if (!rst) begin
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        seen = '{cmd, unit_running, heater_enable, error_active, error_stop, set_temp,
                 measured_temp, tick_second, hot_delay_done, fan_delay_done};
        sb.note_beat(seen);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(result_t'{heater_drive, fan_drive, heating_request, wait_minutes});
      end
    end
  end

  task automatic send_beat(climate_beat_t b);
    int unsigned gap;
    if (beats_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      beats_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    cmd <= b.cmd;
    unit_running <= b.unit_running;
    heater_enable <= b.heater_enable;
    error_active <= b.error_active;
    error_stop <= b.error_stop;
    set_temp <= b.set_temp;
    measured_temp <= b.measured_temp;
    tick_second <= b.tick_second;
    hot_delay_done <= b.hot_delay_done;
    fan_delay_done <= b.fan_delay_done;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_left--;
  endtask

  task automatic step(logic [CmdWidth-1:0] c, logic run, logic en, logic err, logic stop,
                      int set, int meas, logic tick, logic hot_done, logic fan_done);
    climate_beat_t b;
    b = '{c, run, en, err, stop, SetWidth'(set), TempWidth'(meas), tick, hot_done, fan_done};
    send_beat(b);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    beats_left = 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic set_thermostat_limits(logic [7:0] max_w, logic [7:0] base_w,
                                       logic [7:0] burst_w, logic [7:0] start_w,
                                       logic [7:0] hold_w, logic [7:0] cap,
                                       logic [7:0] limit, logic [7:0] boost);
    wait_for_results();
    repeat (2) @(posedge clk);
    cfg_put(REG_MAX_WAIT, max_w);
    cfg_put(REG_BASE_WAIT, base_w);
    cfg_put(REG_BURST, burst_w);
    cfg_put(REG_START_WAIT, start_w);
    cfg_put(REG_HOLD_WAIT, hold_w);
    cfg_put(REG_SP_CAP, cap);
    cfg_put(REG_LOW_LIMIT, limit);
    cfg_put(REG_LOW_BOOST, boost);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_climate(int unsigned count);
    climate_beat_t b;
    int unsigned   sent;
    int unsigned   len;
    int unsigned   roll;
    int            set;
    int            sp;
    int            meas;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        len = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0, 1: set = $urandom_range(0, 127);
          2: set = int'(sb.low_limit) + int'($urandom_range(0, 2)) - 1;
          default: set = int'(sb.sp_cap) + int'($urandom_range(0, 2)) - 1;
        endcase
        if (set < 0) set = 0;
        if (set > 127) set = 127;
        b.set_temp = SetWidth'(set);
        for (int i = 0; i < len && sent < count; i++) begin
          roll = $urandom_range(0, 99);
          b.cmd = (roll < 2) ? CMD_START : (roll < 3) ? CMD_RESET :
                  (roll < 4) ? CMD_UNUSED : CMD_STEP;
          b.unit_running = ($urandom_range(0, 49) != 0);
          b.heater_enable = ($urandom_range(0, 49) != 0);
          b.error_active = ($urandom_range(0, 49) == 0);
          b.error_stop = ($urandom_range(0, 49) == 0);
          sp = sb.target_half_deg(b.set_temp);
          roll = $urandom_range(0, 99);
          if (roll < 84) meas = sp + int'($urandom_range(0, 2)) - 1;
          else if (roll < 92) meas = sp - 2 - int'($urandom_range(0, 12));
          else meas = sp + 2 + int'($urandom_range(0, 12));
          if (meas < TEMP_LO) meas = TEMP_LO;
          if (meas > TEMP_HI) meas = TEMP_HI;
          b.measured_temp = TempWidth'(meas);
          b.tick_second = ($urandom_range(0, 9) != 0);
          b.hot_delay_done = ($urandom_range(0, 9) == 0);
          b.fan_delay_done = ($urandom_range(0, 9) == 0);
          send_beat(b);
          sent++;
        end
      end else begin
        b.cmd = CmdWidth'($urandom_range(0, 3));
        b.unit_running = 1'($urandom_range(0, 1));
        b.heater_enable = 1'($urandom_range(0, 1));
        b.error_active = 1'($urandom_range(0, 1));
        b.error_stop = 1'($urandom_range(0, 1));
        b.set_temp = SetWidth'($urandom_range(0, 127));
        b.measured_temp = TempWidth'(int'($urandom_range(0, TEMP_HI - TEMP_LO)) + TEMP_LO);
        b.tick_second = 1'($urandom_range(0, 1));
        b.hot_delay_done = 1'($urandom_range(0, 1));
        b.fan_delay_done = 1'($urandom_range(0, 1));
        send_beat(b);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) wait_for_results();
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    step(CMD_UNUSED, 1, 1, 0, 0, 40, 80, 1, 1, 1);
    step(CMD_STEP, 0, 1, 0, 0, 40, 80, 1, 0, 0);
    step(CMD_STEP, 1, 1, 0, 0, 20, -80, 1, 0, 0);
    step(CMD_STEP, 1, 1, 0, 0, 20, -80, 0, 1, 0);
    step(CMD_STEP, 1, 1, 0, 0, 40, 80, 1, 0, 0);
    step(CMD_STEP, 1, 1, 0, 0, 127, 250, 1, 0, 0);
    step(CMD_STEP, 1, 1, 0, 0, 127, 250, 1, 0, 1);
    step(CMD_STEP, 1, 1, 0, 0, 40, 79, 1, 0, 0);
    step(CMD_START, 1, 1, 0, 0, 40, 80, 1, 0, 0);
    step(CMD_STEP, 1, 1, 0, 0, 40, 81, 1, 0, 0);
    step(CMD_STEP, 1, 1, 0, 1, 40, 80, 1, 0, 0);
    step(CMD_STEP, 0, 1, 0, 1, 40, 80, 1, 0, 0);
    step(CMD_STEP, 1, 1, 1, 0, 40, 60, 1, 0, 0);
    step(CMD_START, 0, 0, 1, 1, 0, -80, 0, 0, 0);
    step(CMD_STEP, 1, 1, 0, 0, 60, 118, 1, 0, 0);
    step(CMD_RESET, 1, 1, 0, 0, 60, 118, 1, 1, 1);
    step(CMD_STEP, 1, 1, 0, 0, 0, 0, 1, 0, 0);
    step(CMD_STEP, 1, 0, 0, 0, 21, 42, 1, 0, 0);
    step(CMD_STEP, 1, 1, 0, 0, 21, 41, 1, 0, 0);
    step(CMD_STEP, 1, 1, 0, 0, 59, -1, 1, 0, 0);
    step(CMD_STEP, 1, 1, 0, 0, 127, 121, 1, 0, 0);
    step(CMD_UNUSED, 1, 1, 1, 1, 127, -80, 1, 1, 1);
    run_climate(250);

    set_thermostat_limits(8'd4, 8'd1, 8'd1, 8'd1, 8'd2, 8'd60, 8'd20, 8'd3);
    run_climate(500);
    set_thermostat_limits(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_climate(250);
    set_thermostat_limits(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_climate(250);
    set_thermostat_limits(8'd6, 8'd0, 8'd2, 8'd3, 8'd3, 8'd40, 8'd30, 8'd15);
    run_climate(450);
    set_thermostat_limits(8'($urandom_range(0, 8)), 8'($urandom_range(0, 4)),
                          8'($urandom_range(0, 3)), 8'($urandom_range(0, 4)),
                          8'($urandom_range(0, 4)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_climate(250);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
